// ===== sv/ssbpg_pkg.sv =====
package ssbpg_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_IDX_W = 4;
  localparam int LEN_W      = 5;
  localparam int CODE_W     = 3;
  localparam int KIND_W     = 2;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int TIME_W     = 32;
  localparam int DUR_W      = 24;
  localparam int MASK_W     = 12;
  localparam int MS_W       = 16;
  localparam int OCT_W      = 3;
  localparam int PITCH_W    = 9;
  localparam int CLS_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

  // pitch class by reciprocal: floor(n/12) = (n*171) >> 11 for n < 128
  localparam int PC_RECIP = 171;
  localparam int PC_SHIFT = 11;
  localparam int PC_PROD_W = 15;

  localparam logic [MASK_W-1:0]         RST_SCALE_MASK   = 12'd2741;
  localparam logic [SLOTS*CODE_W-1:0]   RST_PATTERN      = 48'd10660392;
  localparam logic [LEN_W-1:0]          RST_LENGTH       = 5'd8;
  localparam logic [MS_W-1:0]           RST_STEP_MS      = 16'd250;
  localparam logic [MS_W-1:0]           RST_HOLD_MS      = 16'd200;
  localparam logic [VEL_W-1:0]          RST_VELOCITY     = 7'd96;
  localparam logic signed [OCT_W-1:0]   RST_OCTAVE       = -3'sd1;
  localparam logic                      RST_PASS_ROOT    = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_ON    = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    CODE_ROOT  = 3'd0,
    CODE_THIRD = 3'd1,
    CODE_FIFTH = 3'd2,
    CODE_UP    = 3'd3,
    CODE_DOWN  = 3'd4,
    CODE_REST  = 3'd5,
    CODE_TIE   = 3'd6,
    CODE_SKIP  = 3'd7
  } step_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_MASK = 3'd0,
    CFG_PATTERN    = 3'd1,
    CFG_LENGTH     = 3'd2,
    CFG_STEP_MS    = 3'd3,
    CFG_HOLD_MS    = 3'd4,
    CFG_VELOCITY   = 3'd5,
    CFG_OCTAVE     = 3'd6,
    CFG_PASS_ROOT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic walk_step;
    logic scan_step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic note_on;
    logic step_zero;
    logic walk_done;
    logic scan_last;
  } dp_stat_t;

endpackage

// ===== sv/scale_step_bass_pattern_generator.sv =====
// channel   ports                                        handshake
// input     in_event_kind/note_number/velocity_in/       start && !busy
//           event_time/duration_in
// result    out_kind/note/velocity/time/duration/last    out_valid, one cycle
// config    cfg_index, cfg_data                          cfg_we
//
// a note-on keeps busy high through W (at most 48) semitone steps of the scale walk that
// finds third and fifth, a check that sees the walk end, L+1 pattern slots at one per cycle
// (L is the length capped at 16) and one flush
// other events, note-offs and note-ons with a zero step go from the walk state to the flush
// results leave one per cycle at most, the last one in the first cycle with busy low
// reset loads the default configuration; no clearing pass
// the receiver cannot stall; out_valid is a single-cycle strobe
module scale_step_bass_pattern_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ssbpg_pkg::KIND_W-1:0]         in_event_kind,
  input  logic [ssbpg_pkg::NOTE_W-1:0]         in_note_number,
  input  logic [ssbpg_pkg::VEL_W-1:0]          in_velocity_in,
  input  logic [ssbpg_pkg::TIME_W-1:0]         in_event_time,
  input  logic [ssbpg_pkg::DUR_W-1:0]          in_duration_in,
  output logic                                 out_valid,
  output logic [ssbpg_pkg::KIND_W-1:0]         out_kind,
  output logic [ssbpg_pkg::NOTE_W-1:0]         out_note,
  output logic [ssbpg_pkg::VEL_W-1:0]          out_velocity,
  output logic [ssbpg_pkg::TIME_W-1:0]         out_time,
  output logic [ssbpg_pkg::DUR_W-1:0]          out_duration,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [ssbpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssbpg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssbpg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ssbpg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ssbpg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_event_kind  (in_event_kind),
    .in_note_number (in_note_number),
    .in_velocity_in (in_velocity_in),
    .in_event_time  (in_event_time),
    .in_duration_in (in_duration_in),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_note       (out_note),
    .out_velocity   (out_velocity),
    .out_time       (out_time),
    .out_duration   (out_duration),
    .out_last       (out_last)
  );

`ifndef NO_ASSERTIONS
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("beat follows the last beat of an item");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-last beat outside an item");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");
`endif

endmodule

// ===== sv/ssbpg_ctrl.sv =====
module ssbpg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ssbpg_pkg::dp_stat_t stat,
  output ssbpg_pkg::dp_cmd_t  cmd
);
  import ssbpg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stat.note_on || stat.step_zero) begin
          state_nxt = ST_FLUSH;
        end else if (stat.walk_done) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== sv/ssbpg_dp.sv =====
module ssbpg_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [ssbpg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ssbpg_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [ssbpg_pkg::KIND_W-1:0]           in_event_kind,
  input  logic [ssbpg_pkg::NOTE_W-1:0]           in_note_number,
  input  logic [ssbpg_pkg::VEL_W-1:0]            in_velocity_in,
  input  logic [ssbpg_pkg::TIME_W-1:0]           in_event_time,
  input  logic [ssbpg_pkg::DUR_W-1:0]            in_duration_in,
  input  ssbpg_pkg::dp_cmd_t                     cmd,
  output ssbpg_pkg::dp_stat_t                    stat,
  output logic                                   out_valid,
  output logic [ssbpg_pkg::KIND_W-1:0]           out_kind,
  output logic [ssbpg_pkg::NOTE_W-1:0]           out_note,
  output logic [ssbpg_pkg::VEL_W-1:0]            out_velocity,
  output logic [ssbpg_pkg::TIME_W-1:0]           out_time,
  output logic [ssbpg_pkg::DUR_W-1:0]            out_duration,
  output logic                                   out_last
);
  import ssbpg_pkg::*;

  // configuration
  logic [MASK_W-1:0]        scale_mask_r;
  logic [SLOTS*CODE_W-1:0]  pattern_r;
  logic [LEN_W-1:0]         length_r;
  logic [MS_W-1:0]          step_ms_r;
  logic [MS_W-1:0]          hold_ms_r;
  logic [VEL_W-1:0]         velocity_r;
  logic signed [OCT_W-1:0]  octave_r;
  logic                     pass_root_r;

  // per item
  logic                     note_on_r;
  logic signed [PITCH_W-1:0] root_r;
  logic signed [PITCH_W-1:0] at_r;
  logic [CLS_W-1:0]         cls_r;
  logic [2:0]               tone_cnt_r;
  logic                     over_r;
  logic signed [PITCH_W-1:0] third_r;
  logic                     third_ok_r;
  logic signed [PITCH_W-1:0] fifth_r;
  logic                     fifth_ok_r;
  logic [LEN_W-1:0]         slot_r;
  logic [TIME_W-1:0]        slot_time_r;
  logic                     open_r;
  logic [NOTE_W-1:0]        open_note_r;
  logic [TIME_W-1:0]        open_time_r;
  logic [DUR_W-1:0]         dur_acc_r;

  // pending result, held until the next one shows whether it is the last
  logic                     pend_valid_r;
  logic [KIND_W-1:0]        pend_kind_r;
  logic [NOTE_W-1:0]        pend_note_r;
  logic [VEL_W-1:0]         pend_vel_r;
  logic [TIME_W-1:0]        pend_time_r;
  logic [DUR_W-1:0]         pend_dur_r;

  logic                     out_valid_r;
  logic [KIND_W-1:0]        out_kind_r;
  logic [NOTE_W-1:0]        out_note_r;
  logic [VEL_W-1:0]         out_vel_r;
  logic [TIME_W-1:0]        out_time_r;
  logic [DUR_W-1:0]         out_dur_r;
  logic                     out_last_r;

  // combinational
  logic [LEN_W-1:0]          len;
  step_code_t                slot_code [SLOTS];
  step_code_t                code;
  logic signed [PITCH_W-1:0] pitch;
  logic                      pitch_ok;
  logic                      is_note_step;
  logic                      emit_new;
  logic [PC_PROD_W-1:0]      pc_prod;
  logic [CLS_W-1:0]          pc_quot;
  logic [NOTE_W-1:0]         pc_rem;
  logic signed [PITCH_W-1:0] oct9;
  logic signed [PITCH_W-1:0] root_in;
  logic signed [PITCH_W-1:0] at_nxt;
  logic [CLS_W-1:0]          cls_nxt;
  logic                      key_hit;
  logic [DUR_W:0]            dur_sum;
  logic [DUR_W-1:0]          dur_tied;

  assign len = (length_r > LEN_W'(SLOTS)) ? LEN_W'(SLOTS) : length_r;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_code[i] = step_code_t'(pattern_r[i*CODE_W +: CODE_W]);
    end
  end

  assign code = (slot_r < len) ? slot_code[slot_r[SLOT_IDX_W-1:0]] : CODE_REST;

  always_comb begin
    pitch    = root_r;
    pitch_ok = 1'b0;
    unique case (code)
      CODE_ROOT: begin
        pitch    = root_r;
        pitch_ok = 1'b1;
      end
      CODE_THIRD: begin
        pitch    = third_r;
        pitch_ok = third_ok_r;
      end
      CODE_FIFTH: begin
        pitch    = fifth_r;
        pitch_ok = fifth_ok_r;
      end
      CODE_UP: begin
        pitch    = root_r + PITCH_W'(12);
        pitch_ok = 1'b1;
      end
      CODE_DOWN: begin
        pitch    = root_r - PITCH_W'(12);
        pitch_ok = 1'b1;
      end
      CODE_REST, CODE_TIE, CODE_SKIP: begin
        pitch    = root_r;
        pitch_ok = 1'b0;
      end
    endcase
    // keep only 0..127
    pitch_ok = pitch_ok && !pitch[PITCH_W-1] && !pitch[PITCH_W-2];
  end

  assign is_note_step = (code != CODE_TIE) && (code != CODE_SKIP);
  assign emit_new     = cmd.scan_step && is_note_step && open_r;

  assign dur_sum  = {1'b0, dur_acc_r} + (DUR_W+1)'(step_ms_r);
  assign dur_tied = dur_sum[DUR_W] ? DUR_MAX : dur_sum[DUR_W-1:0];

  // pitch class of the incoming note; octave shift keeps it
  assign pc_prod = PC_PROD_W'(in_note_number) * PC_PROD_W'(PC_RECIP);
  assign pc_quot = pc_prod[PC_PROD_W-1:PC_SHIFT];
  assign pc_rem  = in_note_number - NOTE_W'(NOTE_W'(pc_quot) * NOTE_W'(12));

  assign oct9    = {{(PITCH_W-OCT_W){octave_r[OCT_W-1]}}, octave_r};
  assign root_in = $signed({2'b00, in_note_number}) + (oct9 <<< 3) + (oct9 <<< 2);

  assign at_nxt  = at_r + PITCH_W'(1);
  assign cls_nxt = (cls_r == CLS_W'(11)) ? '0 : cls_r + CLS_W'(1);
  assign key_hit = (scale_mask_r == '0) || scale_mask_r[cls_nxt];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mask_r <= RST_SCALE_MASK;
      pattern_r    <= RST_PATTERN;
      length_r     <= RST_LENGTH;
      step_ms_r    <= RST_STEP_MS;
      hold_ms_r    <= RST_HOLD_MS;
      velocity_r   <= RST_VELOCITY;
      octave_r     <= RST_OCTAVE;
      pass_root_r  <= RST_PASS_ROOT;
      note_on_r    <= 1'b0;
      over_r       <= 1'b0;
      tone_cnt_r   <= '0;
      third_ok_r   <= 1'b0;
      fifth_ok_r   <= 1'b0;
      slot_r       <= '0;
      open_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SCALE_MASK: scale_mask_r <= cfg_data[MASK_W-1:0];
          CFG_PATTERN:    pattern_r    <= cfg_data[SLOTS*CODE_W-1:0];
          CFG_LENGTH:     length_r     <= cfg_data[LEN_W-1:0];
          CFG_STEP_MS:    step_ms_r    <= cfg_data[MS_W-1:0];
          CFG_HOLD_MS:    hold_ms_r    <= cfg_data[MS_W-1:0];
          CFG_VELOCITY:   velocity_r   <= cfg_data[VEL_W-1:0];
          CFG_OCTAVE:     octave_r     <= $signed(cfg_data[OCT_W-1:0]);
          CFG_PASS_ROOT:  pass_root_r  <= cfg_data[0];
        endcase
      end

      if (cmd.load) begin
        note_on_r   <= (in_event_kind == KIND_ON);
        root_r      <= root_in;
        at_r        <= root_in;
        cls_r       <= pc_rem[CLS_W-1:0];
        tone_cnt_r  <= '0;
        over_r      <= 1'b0;
        third_ok_r  <= 1'b0;
        fifth_ok_r  <= 1'b0;
        slot_r      <= '0;
        slot_time_r <= in_event_time;
        open_r      <= 1'b0;
        pend_note_r <= in_note_number;
        pend_vel_r  <= in_velocity_in;
        pend_time_r <= in_event_time;
        pend_dur_r  <= in_duration_in;
        if (in_event_kind == KIND_ON) begin
          pend_kind_r  <= KIND_ON;
          pend_valid_r <= pass_root_r;
        end else if (in_event_kind == KIND_OFF) begin
          pend_kind_r  <= KIND_OFF;
          pend_valid_r <= pass_root_r;
        end else begin
          pend_kind_r  <= KIND_OTHER;
          pend_valid_r <= 1'b1;
        end
      end

      if (cmd.walk_step) begin
        if (at_nxt > $signed(PITCH_W'(127))) begin
          over_r <= 1'b1;
        end else begin
          at_r  <= at_nxt;
          cls_r <= cls_nxt;
          if (key_hit) begin
            tone_cnt_r <= tone_cnt_r + 3'd1;
            if (tone_cnt_r == 3'd1) begin
              third_r    <= at_nxt;
              third_ok_r <= 1'b1;
            end
            if (tone_cnt_r == 3'd3) begin
              fifth_r    <= at_nxt;
              fifth_ok_r <= 1'b1;
            end
          end
        end
      end

      if (cmd.scan_step) begin
        slot_r      <= slot_r + LEN_W'(1);
        slot_time_r <= slot_time_r + TIME_W'(step_ms_r);
        if (code == CODE_TIE) begin
          if (open_r) begin
            dur_acc_r <= dur_tied;
          end
        end else if (is_note_step) begin
          open_r <= pitch_ok;
          if (pitch_ok) begin
            open_note_r <= pitch[NOTE_W-1:0];
            open_time_r <= slot_time_r;
            dur_acc_r   <= DUR_W'(hold_ms_r);
          end
        end
      end

      if (emit_new) begin
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
          out_kind_r  <= pend_kind_r;
          out_note_r  <= pend_note_r;
          out_vel_r   <= pend_vel_r;
          out_time_r  <= pend_time_r;
          out_dur_r   <= pend_dur_r;
          out_last_r  <= 1'b0;
        end
        pend_valid_r <= 1'b1;
        pend_kind_r  <= KIND_ON;
        pend_note_r  <= open_note_r;
        pend_vel_r   <= velocity_r;
        pend_time_r  <= open_time_r;
        pend_dur_r   <= dur_acc_r;
      end

      if (cmd.flush) begin
        out_valid_r  <= pend_valid_r;
        out_kind_r   <= pend_kind_r;
        out_note_r   <= pend_note_r;
        out_vel_r    <= pend_vel_r;
        out_time_r   <= pend_time_r;
        out_dur_r    <= pend_dur_r;
        out_last_r   <= 1'b1;
        pend_valid_r <= 1'b0;
      end
    end
  end

  assign stat.note_on   = note_on_r;
  assign stat.step_zero = (step_ms_r == '0);
  assign stat.walk_done = over_r || (tone_cnt_r == 3'd4);
  assign stat.scan_last = (slot_r == len);

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_note     = out_note_r;
  assign out_velocity = out_vel_r;
  assign out_time     = out_time_r;
  assign out_duration = out_dur_r;
  assign out_last     = out_last_r;

endmodule

// ===== sim/scale_step_bass_pattern_generator_tb.sv =====
`timescale 1ns / 100ps

module scale_step_bass_pattern_generator_tb;
  import ssbpg_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT = 500;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [TIME_W-1:0] stamp;
    logic [DUR_W-1:0]  dur;
    logic              last;
  } note_event_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [KIND_W-1:0] in_event_kind;
  logic [NOTE_W-1:0] in_note_number;
  logic [VEL_W-1:0] in_velocity_in;
  logic [TIME_W-1:0] in_event_time;
  logic [DUR_W-1:0] in_duration_in;
  logic out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [NOTE_W-1:0] out_note;
  logic [VEL_W-1:0] out_velocity;
  logic [TIME_W-1:0] out_time;
  logic [DUR_W-1:0] out_duration;
  logic out_last;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // register mirror
  logic [MASK_W-1:0] key_mask;
  logic [SLOTS*CODE_W-1:0] step_pattern;
  logic [LEN_W-1:0] pattern_len;
  logic [MS_W-1:0] step_len_ms;
  logic [MS_W-1:0] hold_len_ms;
  logic [VEL_W-1:0] bass_velocity;
  logic signed [OCT_W-1:0] octave_offset;
  logic pass_root_en;

  note_event_t pending_events[$];
  int fail_count = 0;
  int idle_pct = 0;

  scale_step_bass_pattern_generator DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_event_kind  (in_event_kind),
    .in_note_number (in_note_number),
    .in_velocity_in (in_velocity_in),
    .in_event_time  (in_event_time),
    .in_duration_in (in_duration_in),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_note       (out_note),
    .out_velocity   (out_velocity),
    .out_time       (out_time),
    .out_duration   (out_duration),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic string event_text(note_event_t e);
    return $sformatf("kind %0d note %0d vel %0d time %08h dur %0d last %0b",
                     e.kind, e.note, e.vel, e.stamp, e.dur, e.last);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic note_event_t make_event(logic [KIND_W-1:0] kind, logic [NOTE_W-1:0] note,
                                             logic [VEL_W-1:0] vel, logic [TIME_W-1:0] stamp,
                                             logic [DUR_W-1:0] dur);
    note_event_t e;
    e.kind = kind;
    e.note = note;
    e.vel = vel;
    e.stamp = stamp;
    e.dur = dur;
    e.last = 1'b0;
    return e;
  endfunction

  function automatic bit in_scale(int pitch);
    int cls;
    cls = ((pitch % 12) + 12) % 12;
    if (key_mask == '0) begin
      return 1'b1;
    end
    return key_mask[cls];
  endfunction

  // n-th scale tone above base, -1 once the walk passes the top note
  function automatic int scale_tone_above(int base, int n);
    int probe;
    probe = base;
    while (n > 0) begin
      probe++;
      if (probe > 127) begin
        return -1;
      end
      if (in_scale(probe)) begin
        n--;
      end
    end
    return probe;
  endfunction

  function automatic void predict_bass_line(logic [KIND_W-1:0] kind, logic [NOTE_W-1:0] note,
                                            logic [VEL_W-1:0] vel, logic [TIME_W-1:0] stamp,
                                            logic [DUR_W-1:0] dur);
    note_event_t burst[$];
    note_event_t e;
    int root;
    int pitch;
    int held_note;
    int used_slots;
    bit held;
    logic [TIME_W-1:0] held_time;
    longint ties;
    longint span;
    step_code_t code;

    held = 1'b0;
    held_note = 0;
    held_time = '0;
    ties = 0;
    if (kind != KIND_ON) begin
      if (kind == KIND_OFF && !pass_root_en) begin
        return;
      end
      e = make_event((kind == KIND_OFF) ? KIND_OFF : KIND_OTHER, note, vel, stamp, dur);
      e.last = 1'b1;
      pending_events.push_back(e);
      return;
    end

    if (pass_root_en) begin
      burst.push_back(make_event(KIND_ON, note, vel, stamp, dur));
    end

    if (step_len_ms != '0) begin
      root = int'(note) + 12 * int'(octave_offset);
      used_slots = (pattern_len > SLOTS) ? SLOTS : int'(pattern_len);
      for (int slot = 0; slot <= used_slots; slot++) begin
        code = (slot < used_slots) ? step_code_t'(step_pattern[CODE_W*slot +: CODE_W])
                                   : CODE_REST;
        if (code == CODE_SKIP) begin
          continue;
        end
        if (code == CODE_TIE) begin
          if (held) begin
            ties++;
          end
          continue;
        end
        case (code)
          CODE_ROOT:  pitch = root;
          CODE_THIRD: pitch = scale_tone_above(root, 2);
          CODE_FIFTH: pitch = scale_tone_above(root, 4);
          CODE_UP:    pitch = root + 12;
          CODE_DOWN:  pitch = root - 12;
          default:    pitch = -1;
        endcase
        if (held) begin
          span = longint'(hold_len_ms) + ties * longint'(step_len_ms);
          burst.push_back(make_event(KIND_ON, NOTE_W'(held_note), bass_velocity, held_time,
                                     (span > DUR_MAX) ? DUR_MAX : DUR_W'(span)));
          held = 1'b0;
        end
        if (pitch >= 0 && pitch <= 127) begin
          held = 1'b1;
          held_note = pitch;
          held_time = stamp + TIME_W'(slot) * TIME_W'(step_len_ms);
          ties = 0;
        end
      end
    end

    if (burst.size() > 0) begin
      e = burst.pop_back();
      e.last = 1'b1;
      burst.push_back(e);
    end
    foreach (burst[i]) begin
      pending_events.push_back(burst[i]);
    end
  endfunction

  always @(posedge clk) begin : check_beats
    note_event_t got;
    note_event_t want;
    if (rst_n && out_valid) begin
      got = '{kind: out_kind, note: out_note, vel: out_velocity, stamp: out_time,
              dur: out_duration, last: out_last};
      if (pending_events.size() == 0) begin
        note_failure($sformatf("unexpected beat: %s", event_text(got)));
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          note_failure($sformatf("beat mismatch: expected %s, got %s",
                                 event_text(want), event_text(got)));
        end
      end
    end
  end

  task automatic send_event(logic [KIND_W-1:0] kind, logic [NOTE_W-1:0] note,
                            logic [VEL_W-1:0] vel, logic [TIME_W-1:0] stamp,
                            logic [DUR_W-1:0] dur);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_event_kind <= kind;
    in_note_number <= note;
    in_velocity_in <= vel;
    in_event_time <= stamp;
    in_duration_in <= dur;
    do @(posedge clk); while (busy);
    predict_bass_line(kind, note, vel, stamp, dur);
  endtask

  // stop sending, let every expected beat arrive, then let the block go quiet
  task automatic settle_idle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    while (pending_events.size() != 0) begin
      note_failure($sformatf("missing beat: %s", event_text(pending_events.pop_front())));
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SCALE_MASK: key_mask = value[MASK_W-1:0];
      CFG_PATTERN:    step_pattern = value[SLOTS*CODE_W-1:0];
      CFG_LENGTH:     pattern_len = value[LEN_W-1:0];
      CFG_STEP_MS:    step_len_ms = value[MS_W-1:0];
      CFG_HOLD_MS:    hold_len_ms = value[MS_W-1:0];
      CFG_VELOCITY:   bass_velocity = value[VEL_W-1:0];
      CFG_OCTAVE:     octave_offset = value[OCT_W-1:0];
      CFG_PASS_ROOT:  pass_root_en = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic shuffle_settings();
    logic [SLOTS*CODE_W-1:0] pat;
    int pick;
    // mostly playable steps, some rests, ties and skips
    for (int i = 0; i < SLOTS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pat[CODE_W*i +: CODE_W] = CODE_W'($urandom_range(CODE_ROOT, CODE_DOWN));
      end else if (pick < 75) begin
        pat[CODE_W*i +: CODE_W] = CODE_REST;
      end else if (pick < 90) begin
        pat[CODE_W*i +: CODE_W] = CODE_TIE;
      end else begin
        pat[CODE_W*i +: CODE_W] = CODE_SKIP;
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      pat = {16'($urandom), $urandom};
    end
    write_reg(CFG_PATTERN, pat);
    pick = $urandom_range(0, 99);
    write_reg(CFG_SCALE_MASK, CFG_DATA_W'((pick < 15) ? 0 : (pick < 25) ? 12'hFFF :
                              (pick < 40) ? RST_SCALE_MASK : $urandom_range(0, 4095)));
    pick = $urandom_range(0, 99);
    write_reg(CFG_LENGTH, CFG_DATA_W'((pick < 4) ? 0 : (pick < 8) ? $urandom_range(17, 31)
                                                                   : $urandom_range(1, 16)));
    pick = $urandom_range(0, 99);
    write_reg(CFG_STEP_MS, CFG_DATA_W'((pick < 3) ? 0 : (pick < 6) ? 20 :
                           (pick < 8) ? 60000 : (pick < 10) ? 65535
                                                            : $urandom_range(20, 1500)));
    pick = $urandom_range(0, 99);
    write_reg(CFG_HOLD_MS, CFG_DATA_W'((pick < 3) ? 10 : (pick < 5) ? 60000 :
                           (pick < 7) ? 65535 : (pick < 8) ? 0 : $urandom_range(10, 1500)));
    write_reg(CFG_VELOCITY, CFG_DATA_W'($urandom_range(0, 127)));
    write_reg(CFG_OCTAVE, CFG_DATA_W'($urandom_range(0, 7)));
    write_reg(CFG_PASS_ROOT, CFG_DATA_W'($urandom_range(0, 1)));
  endtask

  task automatic send_random_event();
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] stamp;
    int pick;
    pick = $urandom_range(0, 99);
    kind = (pick < 70) ? KIND_ON : (pick < 80) ? KIND_OFF : (pick < 92) ? KIND_OTHER
                                                                        : KIND_SPARE;
    // some start times close to the wrap
    stamp = ($urandom_range(0, 9) == 0) ? (32'hFFFF_0000 | $urandom_range(0, 65535))
                                        : $urandom;
    send_event(kind, NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)),
               stamp, DUR_W'($urandom));
  endtask

  task automatic test_reset_config();
    send_event(KIND_ON, 7'd48, 7'd0, 32'd0, 24'd0);
    send_event(KIND_ON, 7'd127, 7'd127, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_event(KIND_ON, 7'd0, 7'd64, 32'd1000, 24'd500);
    send_event(KIND_OFF, 7'd60, 7'd0, 32'd5, 24'd5);
    send_event(KIND_OTHER, 7'd5, 7'd7, 32'd9, 24'd11);
    send_event(KIND_SPARE, 7'd100, 7'd100, 32'd12345, 24'd678);
  endtask

  task automatic test_pass_through();
    settle_idle();
    write_reg(CFG_PASS_ROOT, 1);
    send_event(KIND_OFF, 7'd127, 7'd0, 32'd0, 24'hFF_FFFF);
    send_event(KIND_ON, 7'd64, 7'd1, 32'h8000_0000, 24'd1);
    send_event(KIND_OTHER, 7'd0, 7'd127, 32'hFFFF_FFFF, 24'd0);
  endtask

  task automatic test_step_codes();
    settle_idle();
    write_reg(CFG_SCALE_MASK, 0);
    // slot 0 on the right: leading tie, root with two ties across a skip,
    // tie after a rest, then every other note code
    write_reg(CFG_PATTERN, CFG_DATA_W'({CODE_ROOT, CODE_DOWN, CODE_UP, CODE_FIFTH, CODE_TIE,
                                        CODE_REST, CODE_THIRD, CODE_TIE, CODE_SKIP, CODE_TIE,
                                        CODE_ROOT, CODE_TIE}));
    write_reg(CFG_LENGTH, 12);
    write_reg(CFG_STEP_MS, 20);
    write_reg(CFG_HOLD_MS, 10);
    write_reg(CFG_VELOCITY, 127);
    write_reg(CFG_OCTAVE, 0);
    write_reg(CFG_PASS_ROOT, 0);
    send_event(KIND_ON, 7'd60, 7'd90, 32'd100, 24'd50);
    send_event(KIND_ON, 7'd125, 7'd90, 32'd200, 24'd50);
    settle_idle();
    write_reg(CFG_SCALE_MASK, 12'hFFF);
    send_event(KIND_ON, 7'd126, 7'd90, 32'd300, 24'd50);
    settle_idle();
    // everything above the top note: no beat at all
    write_reg(CFG_OCTAVE, 3);
    send_event(KIND_ON, 7'd127, 7'd90, 32'd400, 24'd50);
    settle_idle();
    write_reg(CFG_OCTAVE, 3'b100);
    write_reg(CFG_PASS_ROOT, 1);
    send_event(KIND_ON, 7'd0, 7'd90, 32'd500, 24'd50);
    settle_idle();
    // root below zero, fifth lands on note 0 through negative pitch classes
    write_reg(CFG_SCALE_MASK, RST_SCALE_MASK);
    write_reg(CFG_OCTAVE, 3'b111);
    write_reg(CFG_PASS_ROOT, 0);
    send_event(KIND_ON, 7'd5, 7'd90, 32'd600, 24'd50);
  endtask

  task automatic test_pattern_limits();
    settle_idle();
    write_reg(CFG_LENGTH, 0);
    send_event(KIND_ON, 7'd60, 7'd10, 32'd0, 24'd0);
    settle_idle();
    write_reg(CFG_PATTERN, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_LENGTH, 16);
    send_event(KIND_ON, 7'd60, 7'd10, 32'd0, 24'd0);
    settle_idle();
    write_reg(CFG_PATTERN, 0);
    write_reg(CFG_LENGTH, 31);
    write_reg(CFG_STEP_MS, 60000);
    write_reg(CFG_HOLD_MS, 60000);
    write_reg(CFG_PASS_ROOT, 1);
    write_reg(CFG_VELOCITY, 1);
    send_event(KIND_ON, 7'd72, 7'd20, 32'hFFFF_0000, 24'd3);
    settle_idle();
    write_reg(CFG_PATTERN, {{15{CODE_TIE}}, CODE_ROOT});
    write_reg(CFG_LENGTH, 16);
    write_reg(CFG_STEP_MS, 65535);
    write_reg(CFG_HOLD_MS, 65535);
    send_event(KIND_ON, 7'd72, 7'd20, 32'hFFFF_FFF0, 24'd3);
    settle_idle();
    write_reg(CFG_STEP_MS, 0);
    send_event(KIND_ON, 7'd72, 7'd20, 32'd77, 24'd3);
    send_event(KIND_OFF, 7'd72, 7'd0, 32'd99, 24'd0);
  endtask

  task automatic test_random_traffic(int pct, int target);
    int sent;
    int burst;
    idle_pct = pct;
    sent = 0;
    while (sent < target) begin
      settle_idle();
      shuffle_settings();
      burst = $urandom_range(15, 30);
      repeat (burst) send_random_event();
      sent += burst;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_event_kind <= KIND_ON;
    in_note_number <= '0;
    in_velocity_in <= '0;
    in_event_time <= '0;
    in_duration_in <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SCALE_MASK;
    cfg_data <= '0;
    key_mask = RST_SCALE_MASK;
    step_pattern = RST_PATTERN;
    pattern_len = RST_LENGTH;
    step_len_ms = RST_STEP_MS;
    hold_len_ms = RST_HOLD_MS;
    bass_velocity = RST_VELOCITY;
    octave_offset = RST_OCTAVE;
    pass_root_en = RST_PASS_ROOT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 9;
    test_reset_config();
    test_pass_through();
    test_step_codes();
    test_pattern_limits();
    test_random_traffic(9, 100);
    test_random_traffic(73, 100);
    test_random_traffic(0, 100);
    settle_idle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ssbpg_pkg.sv
sv/ssbpg_ctrl.sv
sv/ssbpg_dp.sv
sv/scale_step_bass_pattern_generator.sv
sim/scale_step_bass_pattern_generator_tb.sv
